// ----- hdl/double_ended_queue_defines.svh -----
// assertion macros used by the checker file
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// same-cycle implication, sampled on the rising clock, ignored in reset
`define DEQ_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("double_ended_queue: same-cycle check failed");

// next-cycle implication, sampled on the rising clock, ignored in reset
`define DEQ_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("double_ended_queue: next-cycle check failed");

`endif

// ----- hdl/deq_pkg.sv -----
// types, codes and helpers of the double-ended queue
`timescale 1ns / 1ps

package deq_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int ACTION_W   = 3;
   localparam int VALUE_W    = 32;
   localparam int READ_W     = 32;
   localparam int STATUS_W   = 2;
   localparam int OCC_W      = 5;

   typedef logic [DATA_WIDTH-1:0] data_type;
   typedef logic [PTR_W-1:0]      ptr_type;
   typedef logic [PTR_W:0]        sum_type;
   typedef logic [CNT_W-1:0]      cnt_type;
   typedef logic [ACTION_W-1:0]   action_type;
   typedef logic [VALUE_W-1:0]    value_type;
   typedef logic [READ_W-1:0]     read_type;
   typedef logic [STATUS_W-1:0]   status_type;
   typedef logic [OCC_W-1:0]      occ_type;

   localparam action_type ACT_PUSH_FRONT = 3'd0;
   localparam action_type ACT_PUSH_TAIL  = 3'd1;
   localparam action_type ACT_POP_FRONT  = 3'd2;
   localparam action_type ACT_POP_BACK   = 3'd3;
   localparam action_type ACT_PEEK_FRONT = 3'd4;
   localparam action_type ACT_PEEK_BACK  = 3'd5;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

   localparam sum_type DEPTH_SUM   = sum_type'(DEPTH);
   localparam ptr_type LAST_PTR    = ptr_type'(DEPTH - 1);
   localparam cnt_type DEPTH_CNT   = cnt_type'(DEPTH);

   // entry memory access: write side and read side
   typedef struct packed {
      logic     wr_en;
      ptr_type  wr_addr;
      data_type wr_data;
      logic     rd_en;
      ptr_type  rd_addr;
   } ram_req_type;

   // sum of a ring position and an offset no larger than the depth, folded back into the ring
   function automatic ptr_type ring_wrap(input sum_type sum);
      ptr_type res;
      if (sum >= DEPTH_SUM) begin
         res = ptr_type'(sum - DEPTH_SUM);
      end else begin
         res = ptr_type'(sum);
      end
      return res;
   endfunction

endpackage

// ----- hdl/deq_req_if.sv -----
// request channel: operation and data word
`timescale 1ns / 1ps

interface deq_req_if;
   logic                  valid;
   logic                  ready;
   deq_pkg::action_type   action;
   deq_pkg::value_type    value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);
endinterface

// ----- hdl/deq_rsp_if.sv -----
// response channel: peeked word, status and occupancy
`timescale 1ns / 1ps

interface deq_rsp_if;
   logic                  valid;
   logic                  ready;
   deq_pkg::read_type     read_value;
   deq_pkg::status_type   status;
   deq_pkg::occ_type      occupancy;

   modport source (output valid, output read_value, output status, output occupancy,
                   input ready);
   modport sink   (input valid, input read_value, input status, input occupancy,
                   output ready);
endinterface

// ----- hdl/double_ended_queue.sv -----
// Double-ended queue of 16 words held in a ring buffer in one synchronous memory.
// Takes one operation per cycle while responses are taken (push or pop at either end,
// peek at either end) and returns one response per operation: the peeked word (zero
// otherwise), a status (ok, empty on pop or peek, full on push) and the entry count
// afterwards. A rejected push or pop leaves the queue unchanged. The entry memory is
// read and the pending result registered at the request transfer edge; the response
// register takes both once its slot is free (empty or being taken). With the response
// side ready the block sustains one request every cycle. Head pointer and count live
// in registers and update in the cycle of the request transfer.
`timescale 1ns / 1ps

module double_ended_queue (
   input  logic        clock,
   input  logic        reset,
   deq_req_if.sink     req_ch,
   deq_rsp_if.source   rsp_ch
);

   deq_pkg::ptr_type     head_ff, head_in;
   deq_pkg::cnt_type     count_ff, count_in;
   logic                 pending_ff, pending_in;
   deq_pkg::status_type  pend_status_ff, pend_status_in;
   deq_pkg::cnt_type     pend_count_ff, pend_count_in;
   logic                 pend_peek_ff, pend_peek_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   deq_pkg::read_type    rsp_read_ff, rsp_read_in;
   deq_pkg::status_type  rsp_status_ff, rsp_status_in;
   deq_pkg::occ_type     rsp_occ_ff, rsp_occ_in;

   logic                 req_transfer;
   logic                 pend_move;
   logic                 full;
   logic                 empty;
   deq_pkg::ptr_type     head_dec;
   deq_pkg::ptr_type     head_inc;
   deq_pkg::ptr_type     back_wr;
   deq_pkg::ptr_type     back_rd;
   deq_pkg::ram_req_type ram_req;
   deq_pkg::data_type    rd_data;

   deq_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   assign pend_move    = pending_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !pending_ff || pend_move;
   assign req_transfer = req_ch.valid && req_ch.ready;

   assign full  = (count_ff == deq_pkg::DEPTH_CNT);
   assign empty = (count_ff == '0);

   assign head_dec = (head_ff == '0) ? deq_pkg::LAST_PTR : head_ff - 1'b1;
   assign head_inc = deq_pkg::ring_wrap(deq_pkg::sum_type'(head_ff) + 1'b1);
   assign back_wr  = deq_pkg::ring_wrap(deq_pkg::sum_type'(head_ff)
                                        + deq_pkg::sum_type'(count_ff));
   assign back_rd  = deq_pkg::ring_wrap(deq_pkg::sum_type'(head_ff)
                                        + deq_pkg::sum_type'(count_ff - 1'b1));

   always_comb begin
      head_in        = head_ff;
      count_in       = count_ff;
      pend_status_in = pend_status_ff;
      pend_count_in  = pend_count_ff;
      pend_peek_in   = pend_peek_ff;
      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = back_wr;
      ram_req.wr_data = deq_pkg::data_type'(req_ch.value);
      ram_req.rd_en   = 1'b0;
      ram_req.rd_addr = head_ff;
      if (req_transfer) begin
         pend_status_in = deq_pkg::ST_OK;
         pend_peek_in   = 1'b0;
         unique case (req_ch.action)
            deq_pkg::ACT_PUSH_FRONT: begin
               if (full) begin
                  pend_status_in = deq_pkg::ST_FULL;
               end else begin
                  head_in         = head_dec;
                  count_in        = count_ff + 1'b1;
                  ram_req.wr_en   = 1'b1;
                  ram_req.wr_addr = head_dec;
               end
            end
            deq_pkg::ACT_PUSH_TAIL: begin
               if (full) begin
                  pend_status_in = deq_pkg::ST_FULL;
               end else begin
                  count_in        = count_ff + 1'b1;
                  ram_req.wr_en   = 1'b1;
                  ram_req.wr_addr = back_wr;
               end
            end
            deq_pkg::ACT_POP_FRONT: begin
               if (empty) begin
                  pend_status_in = deq_pkg::ST_EMPTY;
               end else begin
                  head_in  = head_inc;
                  count_in = count_ff - 1'b1;
               end
            end
            deq_pkg::ACT_POP_BACK: begin
               if (empty) begin
                  pend_status_in = deq_pkg::ST_EMPTY;
               end else begin
                  count_in = count_ff - 1'b1;
               end
            end
            deq_pkg::ACT_PEEK_FRONT: begin
               if (empty) begin
                  pend_status_in = deq_pkg::ST_EMPTY;
               end else begin
                  pend_peek_in    = 1'b1;
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = head_ff;
               end
            end
            deq_pkg::ACT_PEEK_BACK: begin
               if (empty) begin
                  pend_status_in = deq_pkg::ST_EMPTY;
               end else begin
                  pend_peek_in    = 1'b1;
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = back_rd;
               end
            end
            default: begin
            end
         endcase
         pend_count_in = count_in;
      end
   end

   always_comb begin
      pending_in    = pending_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_read_in   = rsp_read_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (pend_move) begin
         pending_in    = 1'b0;
         rsp_valid_in  = 1'b1;
         rsp_read_in   = pend_peek_ff ? deq_pkg::read_type'(rd_data) : '0;
         rsp_status_in = pend_status_ff;
         rsp_occ_in    = deq_pkg::occ_type'(pend_count_ff);
      end
      if (req_transfer) begin
         pending_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_status_ff <= pend_status_in;
      pend_count_ff  <= pend_count_in;
      pend_peek_ff   <= pend_peek_in;
      rsp_read_ff    <= rsp_read_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_occ_ff     <= rsp_occ_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.read_value = rsp_read_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.occupancy  = rsp_occ_ff;

endmodule

// ----- hdl/deq_ram.sv -----
// entry memory of the queue, one write and one registered read port
`timescale 1ns / 1ps

module deq_ram (
   input  logic                  clock,
   input  deq_pkg::ram_req_type  ram_req,
   output deq_pkg::data_type     rd_data
);

   deq_pkg::data_type mem [deq_pkg::DEPTH];
   deq_pkg::data_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   // read data only changes on a read, so it holds while the result waits
   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/deq_checker.sv -----
// port checks of the double-ended queue and their binding
`timescale 1ns / 1ps
`include "double_ended_queue_defines.svh"

module deq_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  deq_pkg::read_type    rsp_read_value,
   input  deq_pkg::status_type  rsp_status,
   input  deq_pkg::occ_type     rsp_occupancy
);

   localparam deq_pkg::occ_type OCC_MAX = deq_pkg::occ_type'(deq_pkg::DEPTH);

   logic rsp_full;
   logic rsp_empty;

   assign rsp_full  = rsp_valid && (rsp_status == deq_pkg::ST_FULL);
   assign rsp_empty = rsp_valid && (rsp_status == deq_pkg::ST_EMPTY);

   `DEQ_ASSERT_NEXT(rsp_held, rsp_valid && !rsp_ready, rsp_valid)
   `DEQ_ASSERT_NOW(occ_bounded, rsp_valid, rsp_occupancy <= OCC_MAX)
   `DEQ_ASSERT_NOW(full_at_depth, rsp_full, rsp_occupancy == OCC_MAX)
   `DEQ_ASSERT_NOW(empty_no_data, rsp_empty, rsp_occupancy == '0 && rsp_read_value == '0)

endmodule

bind double_ended_queue deq_checker u_deq_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_read_value (rsp_ch.read_value),
   .rsp_status     (rsp_ch.status),
   .rsp_occupancy  (rsp_ch.occupancy)
);

// ----- tb/sv/tb_top.sv -----
// self-checking testbench of the double-ended queue: directed table, then random traffic
`timescale 1ns / 1ps

module tb_top;

   localparam deq_pkg::action_type ACT_NOOP_LO = 3'd6;
   localparam deq_pkg::action_type ACT_NOOP_HI = 3'd7;
   localparam int RANDOM_OPS = 1450;
   localparam int IDLE_LIMIT = 2000;
   localparam int REPORT_MAX = 10;
   localparam int DIR_ROWS   = 16;

   typedef struct packed {
      deq_pkg::read_type   read_value;
      deq_pkg::status_type status;
      deq_pkg::occ_type    occupancy;
   } deq_result_type;

   typedef struct {
      deq_pkg::action_type act;
      deq_pkg::value_type  val;
      int                  reps;
      bit                  typed;
      deq_pkg::read_type   want_read;
      deq_pkg::status_type want_status;
      deq_pkg::occ_type    want_occ;
   } script_row_type;

   // directed rows; typed rows carry their own answer, the rest use the predictor
   script_row_type directed_ops [DIR_ROWS] = '{
      '{deq_pkg::ACT_POP_FRONT,  32'h0000_0000, 1,  1'b1, 32'h0000_0000, deq_pkg::ST_EMPTY, 5'd0},
      '{deq_pkg::ACT_POP_BACK,   32'h0000_0000, 1,  1'b1, 32'h0000_0000, deq_pkg::ST_EMPTY, 5'd0},
      '{deq_pkg::ACT_PEEK_FRONT, 32'hFFFF_FFFF, 1,  1'b1, 32'h0000_0000, deq_pkg::ST_EMPTY, 5'd0},
      '{deq_pkg::ACT_PEEK_BACK,  32'hFFFF_FFFF, 1,  1'b1, 32'h0000_0000, deq_pkg::ST_EMPTY, 5'd0},
      '{ACT_NOOP_LO,             32'hFFFF_FFFF, 1,  1'b1, 32'h0000_0000, deq_pkg::ST_OK,    5'd0},
      '{deq_pkg::ACT_PUSH_TAIL,  32'hFFFF_FFFF, 1,  1'b1, 32'h0000_0000, deq_pkg::ST_OK,    5'd1},
      '{deq_pkg::ACT_PUSH_FRONT, 32'h0000_0000, 1,  1'b1, 32'h0000_0000, deq_pkg::ST_OK,    5'd2},
      '{deq_pkg::ACT_PEEK_FRONT, 32'h1234_5678, 1,  1'b1, 32'h0000_0000, deq_pkg::ST_OK,    5'd2},
      '{deq_pkg::ACT_PEEK_BACK,  32'h0000_0000, 1,  1'b1, 32'hFFFF_FFFF, deq_pkg::ST_OK,    5'd2},
      '{deq_pkg::ACT_PUSH_TAIL,  32'h8000_0001, 14, 1'b0, 32'h0000_0000, deq_pkg::ST_OK,    5'd0},
      '{deq_pkg::ACT_PUSH_FRONT, 32'hDEAD_BEEF, 1,  1'b1, 32'h0000_0000, deq_pkg::ST_FULL,  5'd16},
      '{deq_pkg::ACT_PUSH_TAIL,  32'hFFFF_FFFF, 1,  1'b1, 32'h0000_0000, deq_pkg::ST_FULL,  5'd16},
      '{ACT_NOOP_HI,             32'h5555_AAAA, 1,  1'b1, 32'h0000_0000, deq_pkg::ST_OK,    5'd16},
      '{deq_pkg::ACT_PEEK_BACK,  32'h0000_0000, 1,  1'b0, 32'h0000_0000, deq_pkg::ST_OK,    5'd0},
      '{deq_pkg::ACT_POP_BACK,   32'h0000_0000, 1,  1'b0, 32'h0000_0000, deq_pkg::ST_OK,    5'd0},
      '{deq_pkg::ACT_POP_FRONT,  32'h0000_0000, 1,  1'b0, 32'h0000_0000, deq_pkg::ST_OK,    5'd0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   deq_req_if req_if ();
   deq_rsp_if rsp_if ();

   double_ended_queue u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // predictor state
   deq_pkg::data_type slot_mem [deq_pkg::DEPTH];
   int front_idx  = 0;
   int fill_count = 0;

   deq_result_type pending_results [$];
   int mismatch_count = 0;
   int idle_cycles    = 0;
   int burst_left     = 0;
   int rx_cycle       = 0;
   int stall_mode     = 0;
   bit progress;
   deq_result_type want;

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic deq_result_type deque_apply(input deq_pkg::action_type act,
                                                  input deq_pkg::value_type val);
      deq_result_type res;
      res = '0;
      res.status = deq_pkg::ST_OK;
      case (act)
         deq_pkg::ACT_PUSH_FRONT: begin
            if (fill_count >= deq_pkg::DEPTH) begin
               res.status = deq_pkg::ST_FULL;
            end else begin
               front_idx = (front_idx + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
               slot_mem[front_idx] = deq_pkg::data_type'(val);
               fill_count++;
            end
         end
         deq_pkg::ACT_PUSH_TAIL: begin
            if (fill_count >= deq_pkg::DEPTH) begin
               res.status = deq_pkg::ST_FULL;
            end else begin
               slot_mem[(front_idx + fill_count) % deq_pkg::DEPTH] = deq_pkg::data_type'(val);
               fill_count++;
            end
         end
         deq_pkg::ACT_POP_FRONT: begin
            if (fill_count == 0) begin
               res.status = deq_pkg::ST_EMPTY;
            end else begin
               front_idx = (front_idx + 1) % deq_pkg::DEPTH;
               fill_count--;
            end
         end
         deq_pkg::ACT_POP_BACK: begin
            if (fill_count == 0) begin
               res.status = deq_pkg::ST_EMPTY;
            end else begin
               fill_count--;
            end
         end
         deq_pkg::ACT_PEEK_FRONT: begin
            if (fill_count == 0) begin
               res.status = deq_pkg::ST_EMPTY;
            end else begin
               res.read_value = deq_pkg::read_type'(slot_mem[front_idx]);
            end
         end
         deq_pkg::ACT_PEEK_BACK: begin
            if (fill_count == 0) begin
               res.status = deq_pkg::ST_EMPTY;
            end else begin
               res.read_value = deq_pkg::read_type'(
                  slot_mem[(front_idx + fill_count - 1) % deq_pkg::DEPTH]);
            end
         end
         default: begin
         end
      endcase
      res.occupancy = deq_pkg::occ_type'(fill_count);
      return res;
   endfunction

   function automatic deq_pkg::value_type pick_word();
      deq_pkg::value_type w;
      case ($urandom_range(0, 9))
         0: w = '0;
         1: w = '1;
         default: w = $urandom;
      endcase
      return w;
   endfunction

   // one request transfer, preceded by a random gap, possibly empty, when a burst runs out
   task automatic send_op(input deq_pkg::action_type act, input deq_pkg::value_type val,
                          input bit typed, input deq_result_type fixed);
      int gap;
      deq_result_type exp;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(40, 160);
            gap = 0;
         end else begin
            burst_left = $urandom_range(1, 8);
            gap = $urandom_range(0, 12);
         end
         repeat (gap) begin
            @(negedge clock);
            req_if.valid <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_if.valid  <= 1'b1;
      req_if.action <= act;
      req_if.value  <= val;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      exp = deque_apply(act, val);
      pending_results.insert(pending_results.size(), typed ? fixed : exp);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_if.valid <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // receiver stall pattern, switched at random among four modes
   always @(negedge clock) begin
      rx_cycle++;
      if (rx_cycle % 128 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_if.ready <= 1'b1;
         1: rsp_if.ready <= ($urandom_range(0, 9) < 7);
         2: rsp_if.ready <= (rx_cycle % 5 != 0);
         default: rsp_if.ready <= (rx_cycle % 16 < 4);
      endcase
   end

   // response check and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         progress = 1'b0;
         if (req_if.valid === 1'b1 && req_if.ready === 1'b1) progress = 1'b1;
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            progress = 1'b1;
            if (pending_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("%0t: unexpected response read %h status %0d occ %0d", $realtime,
                           rsp_if.read_value, rsp_if.status, rsp_if.occupancy);
            end else begin
               want = pending_results.pop_front();
               if (rsp_if.read_value !== want.read_value || rsp_if.status !== want.status ||
                   rsp_if.occupancy !== want.occupancy) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_MAX)
                     $display({"%0t: mismatch, expected read %h status %0d occ %0d,",
                               " got read %h status %0d occ %0d"},
                              $realtime, want.read_value, want.status, want.occupancy,
                              rsp_if.read_value, rsp_if.status, rsp_if.occupancy);
               end
            end
         end
         if (progress) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog, no transfer for %0d cycles", $realtime, IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      int n;
      int k;
      int push_pct;
      deq_pkg::action_type act;
      deq_result_type fixed;

      req_if.valid  = 1'b0;
      req_if.action = deq_pkg::ACT_PUSH_FRONT;
      req_if.value  = '0;
      rsp_if.ready  = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_ops[r]) begin
         fixed.read_value = directed_ops[r].want_read;
         fixed.status     = directed_ops[r].want_status;
         fixed.occupancy  = directed_ops[r].want_occ;
         for (k = 0; k < directed_ops[r].reps; k++)
            send_op(directed_ops[r].act, directed_ops[r].val + deq_pkg::value_type'(k),
                    directed_ops[r].typed, fixed);
      end

      fixed = '0;
      push_pct = 50;
      for (n = 0; n < RANDOM_OPS; n++) begin
         // shift the push/pop balance so the queue swings between empty and full
         if (n % 60 == 0) push_pct = $urandom_range(10, 90);
         if (n % 500 == 250) drain_results();
         if ($urandom_range(0, 19) == 0) begin
            act = $urandom_range(0, 1) ? ACT_NOOP_HI : ACT_NOOP_LO;
         end else if ($urandom_range(0, 99) < push_pct) begin
            act = $urandom_range(0, 1) ? deq_pkg::ACT_PUSH_TAIL : deq_pkg::ACT_PUSH_FRONT;
         end else if ($urandom_range(0, 2) == 0) begin
            act = $urandom_range(0, 1) ? deq_pkg::ACT_PEEK_BACK : deq_pkg::ACT_PEEK_FRONT;
         end else begin
            act = $urandom_range(0, 1) ? deq_pkg::ACT_POP_BACK : deq_pkg::ACT_POP_FRONT;
         end
         send_op(act, pick_word(), 1'b0, fixed);
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
